@@ rtl/ges_pkg.sv @@
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types and constants for the Gaussian elimination solver.
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int ELEM_W      = 32;
  localparam int INDEX_W     = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_W       = 4;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SINGULAR = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    WR_ELEM,
    WR_RDATA,
    WR_TA,
    WR_DIFF
  } wr_sel_t;

  typedef struct packed {
    logic               wr_en;
    wr_sel_t            wr_sel;
    logic               ld_ta_rd;
    logic               ld_ta_diff;
    logic               ld_tb;
    logic               ld_piv;
    logic               ld_fac;
    logic               mul_back;
    logic               div_start;
    logic               div_back;
    logic               sol_wr;
    logic               out_ld;
    err_code_t          out_code;
    logic [INDEX_W-1:0] out_index;
    logic               out_last;
  } ges_cmd_t;

  typedef struct packed {
    logic rdata_zero;
    logic div_done;
    logic div_ovf;
    logic out_busy;
  } ges_stat_t;

endpackage

@@ rtl/ges_div.sv @@
// ----------------------------------------------------------------------------
// ges_div
// Restoring signed fixed-point divider: (num * 2^F) / den, one quotient bit
// per cycle, truncated toward zero, with a 32-bit range overflow flag.
// ----------------------------------------------------------------------------
module ges_div #(
  parameter int FRACTION_BITS = 16,
  localparam int DW = 32 + FRACTION_BITS,
  localparam int CW = $clog2(DW + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [ges_pkg::ELEM_W-1:0] num,
  input  logic signed [ges_pkg::ELEM_W-1:0] den,
  output logic                        done,
  output logic                        ovf,
  output logic signed [ges_pkg::ELEM_W-1:0] quot
);
  import ges_pkg::*;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [32:0]   rem;
  logic [31:0]   dmag;
  logic          neg;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_next;
  logic [31:0] q_low;

  assign num_mag  = num[31] ? 32'(-num) : 32'(num);
  assign den_mag  = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh   = {rem[31:0], dvd[DW-1]};
  assign ge       = rem_sh >= {1'b0, dmag};
  assign rem_next = ge ? rem_sh - {1'b0, dmag} : rem_sh;
  assign q_low    = dvd[31:0];
  assign quot     = neg ? signed'(32'(-q_low)) : signed'(q_low);
  assign ovf      = neg ? (dvd > DW'(33'h080000000)) : (dvd > DW'(33'h07fffffff));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        dvd  <= DW'(num_mag) << FRACTION_BITS;
        rem  <= '0;
        dmag <= den_mag;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ges_dp.sv @@
// ----------------------------------------------------------------------------
// ges_dp
// Solver datapath: matrix memory, solution memory, multiply and truncate
// pipeline, saturating subtract, shared divider and output register.
// ----------------------------------------------------------------------------
module ges_dp #(
  parameter int MAX_EQUATIONS = 8,
  parameter int FRACTION_BITS = 16,
  localparam int MEM_DEPTH = MAX_EQUATIONS * (MAX_EQUATIONS + 1),
  localparam int AW = $clog2(MEM_DEPTH),
  localparam int SW = $clog2(MAX_EQUATIONS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ges_pkg::ges_cmd_t                  cmd,
  output ges_pkg::ges_stat_t                 stat,
  input  logic [AW-1:0]                      rd_addr,
  input  logic [AW-1:0]                      wr_addr,
  input  logic [SW-1:0]                      sol_raddr,
  input  logic [SW-1:0]                      sol_waddr,
  input  logic [ges_pkg::ELEM_W-1:0]         elem,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ges_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast
);
  import ges_pkg::*;

  localparam int PAD = OUT_TDATA_W - INDEX_W - ELEM_W;
  localparam logic signed [63:0] BIAS = (64'sd1 <<< FRACTION_BITS) - 64'sd1;

  logic signed [31:0] mem [MEM_DEPTH];
  logic signed [31:0] sol [MAX_EQUATIONS];
  logic signed [31:0] rdata;
  logic signed [31:0] sdata;
  logic signed [31:0] ta;
  logic signed [31:0] tb;
  logic signed [31:0] piv;
  logic signed [31:0] fac;
  logic signed [63:0] prod;
  logic signed [63:0] quo;

  logic               out_valid;
  logic [INDEX_W-1:0] out_index;
  logic signed [31:0] out_value;
  err_code_t          out_code;
  logic               out_last;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] diff;
  logic signed [31:0] diff_sat;
  logic signed [31:0] wr_data;
  logic signed [31:0] div_num;
  logic signed [31:0] div_den;
  logic               div_done;
  logic               div_ovf;
  logic signed [31:0] div_q;

  assign mul_a   = cmd.mul_back ? sdata : fac;
  assign mul_b   = cmd.mul_back ? rdata : tb;
  assign diff    = 64'(ta) - quo;
  assign div_num = cmd.div_back ? ta : rdata;
  assign div_den = cmd.div_back ? rdata : piv;

  always_comb begin
    if (diff > 64'sd2147483647) begin
      diff_sat = 32'sh7fffffff;
    end else if (diff < -64'sd2147483648) begin
      diff_sat = 32'sh80000000;
    end else begin
      diff_sat = diff[31:0];
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_ELEM:  wr_data = signed'(elem);
      WR_RDATA: wr_data = rdata;
      WR_TA:    wr_data = ta;
      WR_DIFF:  wr_data = diff_sat;
      default:  wr_data = diff_sat;
    endcase
  end

  ges_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .ovf  (div_ovf),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
    if (cmd.sol_wr) begin
      sol[sol_waddr] <= div_q;
    end
    sdata <= sol[sol_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ta_rd) begin
      ta <= rdata;
    end else if (cmd.ld_ta_diff) begin
      ta <= diff_sat;
    end
    if (cmd.ld_tb) begin
      tb <= rdata;
    end
    if (cmd.ld_piv) begin
      piv <= rdata;
    end
    if (cmd.ld_fac) begin
      fac <= div_q;
    end
    prod <= mul_a * mul_b;
    quo  <= (prod + (prod[63] ? BIAS : 64'sd0)) >>> FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_index <= cmd.out_index;
      out_value <= (cmd.out_code == ERR_NONE) ? sdata : 32'sd0;
      out_code  <= cmd.out_code;
      out_last  <= cmd.out_last;
    end
  end

  assign stat.rdata_zero = (rdata == 32'sd0);
  assign stat.div_done   = div_done;
  assign stat.div_ovf    = div_ovf;
  assign stat.out_busy   = out_valid && !m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD{1'b0}}, out_value, out_index};
  assign m_tuser  = out_code;
  assign m_tlast  = out_last;

endmodule

@@ rtl/ges_ctrl.sv @@
// ----------------------------------------------------------------------------
// ges_ctrl
// Solver controller: load sequencing, pivot search with row swaps, forward
// elimination, back substitution and result sequencing.
// ----------------------------------------------------------------------------
module ges_ctrl #(
  parameter int MAX_EQUATIONS = 8,
  localparam int MEM_DEPTH = MAX_EQUATIONS * (MAX_EQUATIONS + 1),
  localparam int AW = $clog2(MEM_DEPTH),
  localparam int SW = $clog2(MAX_EQUATIONS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ges_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        s_tlast,
  input  ges_pkg::ges_stat_t          stat,
  output ges_pkg::ges_cmd_t           cmd,
  output logic [AW-1:0]               rd_addr,
  output logic [AW-1:0]               wr_addr,
  output logic [SW-1:0]               sol_raddr,
  output logic [SW-1:0]               sol_waddr
);
  import ges_pkg::*;

  localparam int NW = $clog2(MAX_EQUATIONS + 2);
  localparam int PW = 2 * NW;
  localparam int LW = $clog2(MEM_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_PIV_RD, S_PIV_CHK, S_SWP_RA, S_SWP_RB, S_SWP_WA, S_SWP_WB,
    S_ELM_RD, S_ELM_DIV, S_ELM_WAIT, S_MAC_RA, S_MAC_RB, S_MAC_MUL, S_MAC_SH,
    S_MAC_WR, S_BCK_RD, S_BCK_LD, S_BCK_RC, S_BCK_MUL, S_BCK_SH, S_BCK_SUB,
    S_BCK_RP, S_BCK_DIV, S_BCK_WAIT, S_OUT_RD, S_OUT_LD, S_ERR
  } state_t;

  state_t          state;
  logic [CFG_W-1:0] eq_count;
  logic [NW-1:0]   cur;
  logic [NW-1:0]   rr;
  logic [NW-1:0]   cc;
  logic [LW-1:0]   load_pos;
  err_code_t       err;

  logic [NW-1:0] n;
  logic [NW-1:0] w;
  logic [NW-1:0] n_m1;
  logic [LW-1:0] limit;
  logic          load_ok;
  logic          s_acc;
  logic [NW-1:0] rd_row;
  logic [NW-1:0] rd_col;
  logic [NW-1:0] wr_row;
  logic [NW-1:0] wr_col;

  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] row,
                                            input logic [NW-1:0] col,
                                            input logic [NW-1:0] wv);
    logic [PW-1:0] rw;
    logic [PW-1:0] cw;
    logic [PW-1:0] ww;
    rw = PW'(row);
    cw = PW'(col);
    ww = PW'(wv);
    return AW'(rw * ww + cw);
  endfunction

  always_comb begin
    if (eq_count == '0) begin
      n = NW'(1);
    end else if (int'(eq_count) > MAX_EQUATIONS) begin
      n = NW'(MAX_EQUATIONS);
    end else begin
      n = NW'(eq_count);
    end
  end

  assign w         = n + NW'(1);
  assign n_m1      = n - NW'(1);
  assign limit     = LW'(PW'(n) * PW'(w));
  assign load_ok   = load_pos < limit;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign sol_raddr = cc[SW-1:0];
  assign sol_waddr = rr[SW-1:0];

  always_comb begin
    cmd    = '0;
    rd_row = cur;
    rd_col = cc;
    wr_row = rr;
    wr_col = cc;
    unique case (state)
      S_IDLE: begin
        cmd.wr_en  = s_acc && load_ok;
        cmd.wr_sel = WR_ELEM;
      end
      S_PIV_RD: begin
        rd_col = cur;
      end
      S_PIV_CHK: begin
        cmd.ld_piv = 1'b1;
      end
      S_SWP_RA: ;
      S_SWP_RB: begin
        cmd.ld_ta_rd = 1'b1;
        rd_row       = rr;
      end
      S_SWP_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RDATA;
        wr_row     = cur;
      end
      S_SWP_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_TA;
      end
      S_ELM_RD: begin
        rd_row = rr;
        rd_col = cur;
      end
      S_ELM_DIV: begin
        cmd.div_start = 1'b1;
      end
      S_ELM_WAIT: begin
        cmd.ld_fac = stat.div_done;
      end
      S_MAC_RA: ;
      S_MAC_RB: begin
        cmd.ld_tb = 1'b1;
        rd_row    = rr;
      end
      S_MAC_MUL: begin
        cmd.ld_ta_rd = 1'b1;
      end
      S_MAC_SH: ;
      S_MAC_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_DIFF;
      end
      S_BCK_RD: begin
        rd_row = rr;
        rd_col = n;
      end
      S_BCK_LD: begin
        cmd.ld_ta_rd = 1'b1;
      end
      S_BCK_RC: begin
        rd_row = rr;
      end
      S_BCK_MUL: begin
        cmd.mul_back = 1'b1;
      end
      S_BCK_SH: ;
      S_BCK_SUB: begin
        cmd.ld_ta_diff = 1'b1;
      end
      S_BCK_RP: begin
        rd_row = rr;
        rd_col = rr;
      end
      S_BCK_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_back  = 1'b1;
      end
      S_BCK_WAIT: begin
        cmd.sol_wr = stat.div_done && !stat.div_ovf;
      end
      S_OUT_RD: ;
      S_OUT_LD: begin
        cmd.out_ld    = !stat.out_busy;
        cmd.out_code  = ERR_NONE;
        cmd.out_index = INDEX_W'(cc);
        cmd.out_last  = (cc == n_m1);
      end
      S_ERR: begin
        cmd.out_ld   = !stat.out_busy;
        cmd.out_code = err;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
    rd_addr = addr_of(rd_row, rd_col, w);
    wr_addr = (state == S_IDLE) ? load_pos[AW-1:0] : addr_of(wr_row, wr_col, w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      eq_count <= CFG_W'(8);
      load_pos <= '0;
      cur      <= '0;
      rr       <= '0;
      cc       <= '0;
      err      <= ERR_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eq_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (s_tlast) begin
              load_pos <= '0;
              cur      <= '0;
              rr       <= NW'(1);
              state    <= S_PIV_RD;
            end else if (load_ok) begin
              load_pos <= load_pos + LW'(1);
            end
          end
        end
        S_PIV_RD: state <= S_PIV_CHK;
        S_PIV_CHK: begin
          if (stat.rdata_zero) begin
            if (rr < n) begin
              cc    <= '0;
              state <= S_SWP_RA;
            end else begin
              err   <= ERR_SINGULAR;
              state <= S_ERR;
            end
          end else if (cur + NW'(1) < n) begin
            rr    <= cur + NW'(1);
            state <= S_ELM_RD;
          end else begin
            rr    <= n_m1;
            state <= S_BCK_RD;
          end
        end
        S_SWP_RA: state <= S_SWP_RB;
        S_SWP_RB: state <= S_SWP_WA;
        S_SWP_WA: state <= S_SWP_WB;
        S_SWP_WB: begin
          if (cc == n) begin
            rr    <= rr + NW'(1);
            state <= S_PIV_RD;
          end else begin
            cc    <= cc + NW'(1);
            state <= S_SWP_RA;
          end
        end
        S_ELM_RD:  state <= S_ELM_DIV;
        S_ELM_DIV: state <= S_ELM_WAIT;
        S_ELM_WAIT: begin
          if (stat.div_done) begin
            if (stat.div_ovf) begin
              err   <= ERR_OVERFLOW;
              state <= S_ERR;
            end else begin
              cc    <= cur;
              state <= S_MAC_RA;
            end
          end
        end
        S_MAC_RA:  state <= S_MAC_RB;
        S_MAC_RB:  state <= S_MAC_MUL;
        S_MAC_MUL: state <= S_MAC_SH;
        S_MAC_SH:  state <= S_MAC_WR;
        S_MAC_WR: begin
          if (cc == n) begin
            if (rr + NW'(1) < n) begin
              rr    <= rr + NW'(1);
              state <= S_ELM_RD;
            end else begin
              cur   <= cur + NW'(1);
              rr    <= cur + NW'(2);
              state <= S_PIV_RD;
            end
          end else begin
            cc    <= cc + NW'(1);
            state <= S_MAC_RA;
          end
        end
        S_BCK_RD: state <= S_BCK_LD;
        S_BCK_LD: begin
          cc <= n_m1;
          if (n_m1 > rr) begin
            state <= S_BCK_RC;
          end else begin
            state <= S_BCK_RP;
          end
        end
        S_BCK_RC:  state <= S_BCK_MUL;
        S_BCK_MUL: state <= S_BCK_SH;
        S_BCK_SH:  state <= S_BCK_SUB;
        S_BCK_SUB: begin
          cc <= cc - NW'(1);
          if (cc - NW'(1) > rr) begin
            state <= S_BCK_RC;
          end else begin
            state <= S_BCK_RP;
          end
        end
        S_BCK_RP:  state <= S_BCK_DIV;
        S_BCK_DIV: state <= S_BCK_WAIT;
        S_BCK_WAIT: begin
          if (stat.div_done) begin
            if (stat.div_ovf) begin
              err   <= ERR_OVERFLOW;
              state <= S_ERR;
            end else if (rr == '0) begin
              cc    <= '0;
              state <= S_OUT_RD;
            end else begin
              rr    <= rr - NW'(1);
              state <= S_BCK_RD;
            end
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          if (!stat.out_busy) begin
            if (cc == n_m1) begin
              state <= S_IDLE;
            end else begin
              cc    <= cc + NW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        S_ERR: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/gaussian_elimination_solver_unit.sv @@
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit
// Solves an N by N linear system in signed fixed point by Gaussian
// elimination with row swaps on zero pivots and back substitution.
// ----------------------------------------------------------------------------
// Usage: write the equation count N on the cfg channel while the block is
// idle (reset value 8). Stream the augmented matrix row by row on the s_
// channel, N coefficients then the constant for each row; s_tlast on the
// last element starts the solve. Elements are accepted one per cycle while idle.
// The solve then runs in place on a matrix memory with one read and one
// write port, one shared multiplier and one bit-serial divider: a
// multiply-subtract reads its operands, multiplies, truncates and writes
// back, a pivot swap reads and writes both rows at each column, and a
// division reads its operand and waits for the divider result. s_tready
// is low for the whole solve.
// Results leave on the m_ channel one per unknown in index order, the last
// marked by m_tlast, or as a single error result. The output register
// holds a result while m_tready is low and the sequencer waits on it.
// Reset clears the load position and the output valid and sets the
// equation count to 8.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_unit #(
  parameter int MAX_EQUATIONS = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ges_pkg::CFG_W-1:0]       cfg_data,      // equation_count
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ges_pkg::ELEM_W-1:0]      s_tdata,       // element_value
  input  logic                            s_tlast,       // final_element
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ges_pkg::OUT_TDATA_W-1:0] m_tdata,       // unknown_index, solution_value
  output logic [1:0]                      m_tuser,       // error_code
  output logic                            m_tlast        // last_result
);
  import ges_pkg::*;

  localparam int MEM_DEPTH = MAX_EQUATIONS * (MAX_EQUATIONS + 1);
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SW = $clog2(MAX_EQUATIONS);

  ges_cmd_t      cmd;
  ges_stat_t     stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] sol_raddr;
  logic [SW-1:0] sol_waddr;

  ges_ctrl #(
    .MAX_EQUATIONS(MAX_EQUATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .sol_raddr(sol_raddr),
    .sol_waddr(sol_waddr)
  );

  ges_dp #(
    .MAX_EQUATIONS(MAX_EQUATIONS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .sol_raddr(sol_raddr),
    .sol_waddr(sol_waddr),
    .elem     (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/ges_chk.sv @@
// ----------------------------------------------------------------------------
// ges_chk
// Port-level checks on the result channel of the solver.
// ----------------------------------------------------------------------------
module ges_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ges_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast
);
  import ges_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ERR_NONE) |-> m_tlast && (m_tdata == '0))
    else $error("error result is not a lone zero transfer");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind gaussian_elimination_solver_unit ges_chk u_ges_chk (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
